// ===== rtl/xt_pkg.sv =====
// Shared types, constants and mixing functions of the XXTEA block cipher.
package xt_pkg;

  // Round constant of the cipher.
  localparam logic [31:0] XT_DELTA = 32'h9e3779b9;

  // Widths of the controller-to-datapath command fields, sized for the largest block.
  localparam int XT_IDX_W = 6;
  localparam int XT_CNT_W = 7;
  localparam int XT_RND_W = 6;

  // One input transaction.
  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
    logic        decrypt_mode;
  } xt_in_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] result_word;
    logic        result_last;
    logic        overflow;
  } xt_out_t;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic                we;
    logic                wsel_mix;
    logic [XT_IDX_W-1:0] waddr;
    logic [XT_IDX_W-1:0] rd_idx;
    logic                load_chain;
    logic                init_sum;
    logic                step_sum;
    logic                dec;
    logic [XT_CNT_W-1:0] n;
    logic [XT_RND_W-1:0] rounds;
  } xt_cmd_t;

  // Number of full rounds for a block of n words, n of at least 2: 6 + 52/n.
  function automatic logic [XT_RND_W-1:0] xt_rounds(input logic [XT_CNT_W-1:0] n);
    logic [XT_RND_W-1:0] r;
    priority if (n <= 7'd2)  r = 6'd32;
    else if (n == 7'd3)      r = 6'd23;
    else if (n == 7'd4)      r = 6'd19;
    else if (n == 7'd5)      r = 6'd16;
    else if (n == 7'd6)      r = 6'd14;
    else if (n == 7'd7)      r = 6'd13;
    else if (n == 7'd8)      r = 6'd12;
    else if (n <= 7'd10)     r = 6'd11;
    else if (n <= 7'd13)     r = 6'd10;
    else if (n <= 7'd17)     r = 6'd9;
    else if (n <= 7'd26)     r = 6'd8;
    else if (n <= 7'd52)     r = 6'd7;
    else                     r = 6'd6;
    return r;
  endfunction

  // Standard MX mixing term; k is the already selected key word.
  function automatic logic [31:0] xt_mix(input logic [31:0] y, input logic [31:0] z,
                                         input logic [31:0] sum, input logic [31:0] k);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = (z >> 5) ^ (y << 2);
    b = (y >> 3) ^ (z << 4);
    c = sum ^ y;
    d = k ^ z;
    return (a + b) ^ (c + d);
  endfunction

endpackage

// ===== rtl/xt_dpath.sv =====
// Datapath of the XXTEA block cipher: word store, key registers and mixing step.
module xt_dpath import xt_pkg::*; #(
  parameter int MAX_WORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  xt_cmd_t     cmd_i,
  input  logic [31:0] word_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic [31:0] rdata_o
);

  localparam int IW = $clog2(MAX_WORDS);

  logic [31:0] mem [MAX_WORDS];
  logic [31:0] key_q [4];
  logic [31:0] rd0_q, rd1_q;
  logic        fwd0_q, fwd1_q;
  logic [31:0] fwd_data_q;
  logic [31:0] chain_q, sum_q;

  logic [IW-1:0]       raddr0, raddr1, waddr, nm1;
  logic [XT_CNT_W-1:0] nm1_full;
  logic [31:0]         wdata, data0, data1, y, z, mix_term, new_word, key_sel, rnd_sum;
  logic [1:0]          kidx;

  // Read addresses: the word to update and its neighbor in the direction of travel.
  assign nm1_full = cmd_i.n - XT_CNT_W'(1);
  assign nm1      = nm1_full[IW-1:0];
  assign raddr0   = cmd_i.rd_idx[IW-1:0];
  assign waddr    = cmd_i.waddr[IW-1:0];

  always_comb begin
    if (cmd_i.dec) begin
      raddr1 = (raddr0 == '0) ? nm1 : raddr0 - IW'(1);
    end else begin
      raddr1 = (raddr0 == nm1) ? '0 : raddr0 + IW'(1);
    end
  end

  // Word store with one write port and two registered read ports.
  assign wdata = cmd_i.wsel_mix ? new_word : word_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[waddr] <= wdata;
    end
    rd0_q <= mem[raddr0];
    rd1_q <= mem[raddr1];
  end

  // A read issued in the cycle of a write to the same entry gets the new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd0_q <= 1'b0;
      fwd1_q <= 1'b0;
    end else begin
      fwd0_q <= cmd_i.we && (waddr == raddr0);
      fwd1_q <= cmd_i.we && (waddr == raddr1);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
  end

  assign data0   = fwd0_q ? fwd_data_q : rd0_q;
  assign data1   = fwd1_q ? fwd_data_q : rd1_q;
  assign rdata_o = data0;

  // Key registers, written through the configuration channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // One mixing step: encryption chains z, decryption chains y.
  assign kidx    = 2'(waddr) ^ sum_q[3:2];
  assign key_sel = key_q[kidx];
  assign y       = cmd_i.dec ? chain_q : data1;
  assign z       = cmd_i.dec ? data1 : chain_q;
  assign mix_term = xt_mix(y, z, sum_q, key_sel);
  assign new_word = cmd_i.dec ? (data0 - mix_term) : (data0 + mix_term);

  // Starting sum for decryption is rounds times delta, modulo 2^32.
  assign rnd_sum = 32'(cmd_i.rounds) * XT_DELTA;

  // Chain word and round sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_chain) begin
      chain_q <= data0;
    end else if (cmd_i.we && cmd_i.wsel_mix) begin
      chain_q <= new_word;
    end
    if (cmd_i.init_sum) begin
      sum_q <= cmd_i.dec ? rnd_sum : XT_DELTA;
    end else if (cmd_i.step_sum) begin
      sum_q <= cmd_i.dec ? (sum_q - XT_DELTA) : (sum_q + XT_DELTA);
    end
  end

endmodule

// ===== rtl/xt_ctrl.sv =====
// Controller of the XXTEA block cipher: word collection, round sequencing and result readout.
module xt_ctrl import xt_pkg::*; #(
  parameter int MAX_WORDS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  xt_in_t  in_i,
  output logic    busy_o,
  output xt_cmd_t cmd_o,
  output logic    valid_o,
  output logic    last_o,
  output logic    ovf_o
);

  localparam int IW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PRIME = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_MIX   = 5'b01000,
    ST_EMIT  = 5'b10000
  } xt_state_e;

  xt_state_e           state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic                dec_q, dec_d;
  logic [IW-1:0]       p_q, p_d;
  logic [IW-1:0]       k_q, k_d;
  logic [XT_RND_W-1:0] rnd_q, rnd_d;
  logic                valid_q, valid_d;
  logic                last_q, last_d;
  logic                oflag_q, oflag_d;

  logic [CW-1:0]       nm1_full, n_new;
  logic [IW-1:0]       nm1, p_next, rd_idx, waddr;
  logic                full, round_end;
  logic [XT_RND_W-1:0] rounds;

  assign full     = (cnt_q == CW'(MAX_WORDS));
  assign n_new    = full ? cnt_q : cnt_q + CW'(1);
  assign nm1_full = cnt_q - CW'(1);
  assign nm1      = nm1_full[IW-1:0];
  assign rounds   = xt_rounds(XT_CNT_W'(cnt_q));

  // Step order: upward for encryption, downward for decryption, wrapping at the block end.
  assign round_end = dec_q ? (p_q == '0) : (p_q == nm1);
  always_comb begin
    if (dec_q) begin
      p_next = (p_q == '0) ? nm1 : p_q - IW'(1);
    end else begin
      p_next = (p_q == nm1) ? '0 : p_q + IW'(1);
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    dec_d   = dec_q;
    p_d     = p_q;
    k_d     = k_q;
    rnd_d   = rnd_q;
    valid_d = 1'b0;
    last_d  = last_q;
    oflag_d = oflag_q;
    rd_idx  = p_q;
    waddr   = cnt_q[IW-1:0];
    busy_o  = 1'b1;
    cmd_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (!full) begin
            cmd_o.we = 1'b1;
            cnt_d    = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_word) begin
            dec_d = in_i.decrypt_mode;
            k_d   = '0;
            if (n_new > CW'(1)) begin
              state_d = ST_PRIME;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_PRIME: begin
        // Fetch the word that starts the chain.
        rd_idx         = dec_q ? '0 : nm1;
        cmd_o.init_sum = 1'b1;
        rnd_d          = rounds;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_chain = 1'b1;
        rd_idx           = dec_q ? nm1 : '0;
        p_d              = rd_idx;
        state_d          = ST_MIX;
      end
      ST_MIX: begin
        // One word updated per cycle; the next step's words are fetched meanwhile.
        cmd_o.we       = 1'b1;
        cmd_o.wsel_mix = 1'b1;
        waddr          = p_q;
        rd_idx         = p_next;
        p_d            = p_next;
        if (round_end) begin
          cmd_o.step_sum = 1'b1;
          rnd_d          = rnd_q - XT_RND_W'(1);
          if (rnd_q == XT_RND_W'(1)) begin
            state_d = ST_EMIT;
            k_d     = '0;
          end
        end
      end
      ST_EMIT: begin
        rd_idx  = k_q;
        valid_d = 1'b1;
        last_d  = (k_q == nm1);
        oflag_d = ovf_q;
        if (k_q == nm1) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    cmd_o.rd_idx = XT_IDX_W'(rd_idx);
    cmd_o.waddr  = XT_IDX_W'(waddr);
    cmd_o.dec    = dec_q;
    cmd_o.n      = XT_CNT_W'(cnt_q);
    cmd_o.rounds = rounds;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  // Sequencing registers that are only read after being loaded.
  always_ff @(posedge clk_i) begin
    dec_q   <= dec_d;
    p_q     <= p_d;
    k_q     <= k_d;
    rnd_q   <= rnd_d;
    last_q  <= last_d;
    oflag_q <= oflag_d;
  end

  assign valid_o = valid_q;
  assign last_o  = last_q;
  assign ovf_o   = oflag_q;

endmodule

// ===== rtl/xxtea_block_cipher.sv =====
// Top level of the XXTEA block cipher over a stream of 32-bit words.
//
// Input words arrive as transactions on start_i/data_i, taken when start_i is high
// and busy_o is low. A word with last_word set closes the
// block and selects encryption or decryption. Words past MAX_WORDS are dropped and
// flag overflow on every result of that block.
// After the closing word the block is busy through a priming state, a chain-load
// state, rounds*n mixing steps with rounds = 6 + 52/n, done one at a time through the
// single word-update unit and the store's read/write ports, then a readout of each word.
// A one-word block skips the rounds and goes straight to readout.
// Results appear one per cycle on result_o, each marked by result_valid_o for one
// cycle, the first in the cycle after readout starts; the receiver cannot stall them.
// The key registers are written on cfg_valid_i/cfg_ready_o, always ready; the user
// must write them only while idle, as the block itself does not enforce it.
// Reset clears the keys, the word count and the overflow flag.
module xxtea_block_cipher import xt_pkg::*; #(
  parameter int MAX_WORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  xt_in_t      data_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output xt_out_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  xt_cmd_t     cmd;
  logic [31:0] rdata;
  logic        res_last, res_ovf;

  // Sequencer.
  xt_ctrl #(
    .MAX_WORDS(MAX_WORDS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (data_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .valid_o(result_valid_o),
    .last_o (res_last),
    .ovf_o  (res_ovf)
  );

  // Store, keys and mixing unit.
  xt_dpath #(
    .MAX_WORDS(MAX_WORDS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .word_i     (data_i.data_word),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rdata_o    (rdata)
  );

  assign cfg_ready_o          = 1'b1;
  assign result_o.result_word = rdata;
  assign result_o.result_last = res_last;
  assign result_o.overflow    = res_ovf;

  // Results of one block come out back to back.
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.result_last |=> result_valid_o)
    else $error("result stream of a block was interrupted");

  // A block's final result is not followed directly by another result.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.result_last |=> !result_valid_o)
    else $error("result directly after the final result of a block");

  // A closing word always makes the block busy.
  a_close_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && data_i.last_word |=> busy_o)
    else $error("closing word did not start processing");

endmodule
